// ===== hdl/assert_macros.svh =====
// Assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lc3x_pkg.sv =====
// ---------------------------------------------------------------------------
// lc3x_pkg
// Shared types, codes and helpers of the LC-3 style instruction executor.
// ---------------------------------------------------------------------------
package lc3x_pkg;

    localparam int unsigned MEM_WORDS_DEF = 4096;
    localparam logic [15:0] REG_RESET     = 16'h7777;
    localparam logic [15:0] SIGN_BIT      = 16'h8000;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_STEP   = 2'd0;
    localparam logic [1:0] KIND_DUMP   = 2'd1;
    localparam logic [1:0] KIND_IGNORE = 2'd2;

    // condition codes
    localparam logic [1:0] CC_NEG  = 2'd0;
    localparam logic [1:0] CC_ZERO = 2'd1;
    localparam logic [1:0] CC_POS  = 2'd2;

    // opcodes
    localparam logic [3:0] OPC_BR   = 4'd0;
    localparam logic [3:0] OPC_ADD  = 4'd1;
    localparam logic [3:0] OPC_LD   = 4'd2;
    localparam logic [3:0] OPC_ST   = 4'd3;
    localparam logic [3:0] OPC_JSR  = 4'd4;
    localparam logic [3:0] OPC_AND  = 4'd5;
    localparam logic [3:0] OPC_LDR  = 4'd6;
    localparam logic [3:0] OPC_STR  = 4'd7;
    localparam logic [3:0] OPC_NOT  = 4'd9;
    localparam logic [3:0] OPC_LDI  = 4'd10;
    localparam logic [3:0] OPC_STI  = 4'd11;
    localparam logic [3:0] OPC_JMP  = 4'd12;
    localparam logic [3:0] OPC_LEA  = 4'd14;
    localparam logic [3:0] OPC_TRAP = 4'd15;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [15:0] data;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reg_index;
        logic [15:0] value;
        logic [1:0]  cond;
        logic        last;
    } out_word_t;

    function automatic logic [15:0] sext9(input logic [15:0] ir);
        sext9 = {{7{ir[8]}}, ir[8:0]};
    endfunction

    function automatic logic [15:0] sext6(input logic [15:0] ir);
        sext6 = {{10{ir[5]}}, ir[5:0]};
    endfunction

    function automatic logic [15:0] sext5(input logic [15:0] ir);
        sext5 = {{11{ir[4]}}, ir[4:0]};
    endfunction

    function automatic logic [15:0] sext11(input logic [15:0] ir);
        sext11 = {{5{ir[10]}}, ir[10:0]};
    endfunction

    function automatic logic [1:0] cc_of(input logic [15:0] w);
        if (w == 16'd0)
            cc_of = CC_ZERO;
        else if ((w & SIGN_BIT) != 16'd0)
            cc_of = CC_NEG;
        else
            cc_of = CC_POS;
    endfunction

endpackage

// ===== hdl/lc3x_front.sv =====
// ---------------------------------------------------------------------------
// lc3x_front
// Accepts input words and pushes them into a short queue.
// ---------------------------------------------------------------------------
module lc3x_front
    import lc3x_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    output logic     q_valid,
    input  logic     q_pop,
    output in_word_t q_word
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    in_word_t        fifo_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            push;

    assign in_ready = (cnt_reg != (PW+1)'(DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_word   = fifo_reg[rd_reg];

    // pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (q_pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (push && !q_pop)
            cnt_next = cnt_reg + (PW+1)'(1);
        else if (!push && q_pop)
            cnt_next = cnt_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_reg] <= in_word;
    end

endmodule

// ===== hdl/lc3x_back.sv =====
// ---------------------------------------------------------------------------
// lc3x_back
// Sequencer that fetches and executes instructions and drives results.
// ---------------------------------------------------------------------------
module lc3x_back
    import lc3x_pkg::*;
#(
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] origin,
    input  logic        q_valid,
    output logic        q_pop,
    input  in_word_t    q_word,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_word
);

    localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_IND   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_DUMP  = 3'd6;

    logic [15:0]   mem [MEM_WORDS];
    logic [15:0]   rdata_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    logic [2:0]  state_reg, state_next;
    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg, pc_next;
    logic [1:0]  cc_reg, cc_next;
    logic        halt_reg, halt_next;
    logic [15:0] ir_reg, ir_next;
    logic [2:0]  di_reg, di_next;
    logic        ov_reg, ov_next;
    out_word_t   ow_reg, ow_next;
    logic        rf_we;
    logic [2:0]  rf_wa;
    logic [15:0] rf_wd;

    logic [3:0]  opc;
    logic [15:0] pc1, a_sr1, a_dr, b_op, alu, ea_pc, ea_base;

    assign opc     = ir_reg[15:12];
    assign pc1     = pc_reg + 16'd1;
    assign a_sr1   = rf_reg[ir_reg[8:6]];
    assign a_dr    = rf_reg[ir_reg[11:9]];
    assign b_op    = ir_reg[5] ? sext5(ir_reg) : rf_reg[ir_reg[2:0]];
    assign alu     = (opc == OPC_ADD) ? a_sr1 + b_op : a_sr1 & b_op;
    assign ea_pc   = pc1 + sext9(ir_reg);
    assign ea_base = a_sr1 + sext6(ir_reg) - origin;

    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cc_next    = cc_reg;
        halt_next  = halt_reg;
        ir_next    = ir_reg;
        di_next    = di_reg;
        ov_next    = ov_reg;
        ow_next    = ow_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = pc_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = ea_pc[AW-1:0];
        wr_data    = a_dr;
        rf_we      = 1'b0;
        rf_wa      = ir_reg[11:9];
        rf_wd      = rdata_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && (!ov_reg || out_ready))
                begin
                    q_pop = 1'b1;
                    if (q_word.operation == OP_LOAD)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(q_word.address - origin);
                        wr_data = q_word.data;
                    end
                    else if (halt_reg)
                    begin
                        ov_next = 1'b1;
                        ow_next = '{KIND_IGNORE, 3'd0, 16'd0, cc_reg, 1'b1};
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = pc_reg[AW-1:0];
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                ir_next    = rdata_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                pc_next    = pc1;
                state_next = S_OUT;
                unique case (opc)
                    OPC_BR:
                        if ((ir_reg[11] && cc_reg == CC_NEG) ||
                            (ir_reg[10] && cc_reg == CC_ZERO) ||
                            (ir_reg[9] && cc_reg == CC_POS))
                            pc_next = ea_pc;
                    OPC_ADD, OPC_AND:
                    begin
                        rf_we   = 1'b1;
                        rf_wd   = alu;
                        cc_next = cc_of(alu);
                    end
                    OPC_NOT:
                    begin
                        rf_we   = 1'b1;
                        rf_wd   = ~a_sr1;
                        cc_next = cc_of(~a_sr1);
                    end
                    OPC_LD, OPC_LDI:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ea_pc[AW-1:0];
                        state_next = (opc == OPC_LD) ? S_FIN : S_IND;
                    end
                    OPC_LDR:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ea_base[AW-1:0];
                        state_next = S_FIN;
                    end
                    OPC_ST:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ea_pc[AW-1:0];
                        cc_next = cc_of(a_dr);
                    end
                    OPC_STR:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ea_base[AW-1:0];
                        cc_next = cc_of(a_dr);
                    end
                    OPC_STI:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ea_pc[AW-1:0];
                        state_next = S_IND;
                    end
                    OPC_JSR:
                    begin
                        rf_we   = 1'b1;
                        rf_wa   = 3'd7;
                        rf_wd   = pc1 + origin;
                        pc_next = ir_reg[11] ? pc1 + sext11(ir_reg) : a_sr1 - origin;
                    end
                    OPC_JMP:
                        pc_next = a_sr1 - origin;
                    OPC_LEA:
                    begin
                        rf_we = 1'b1;
                        rf_wd = ea_pc + origin;
                    end
                    OPC_TRAP:
                    begin
                        halt_next  = 1'b1;
                        di_next    = 3'd0;
                        state_next = S_DUMP;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_IND:
            begin
                // pointer word arrived; second access
                if (opc == OPC_LDI)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(rdata_reg - origin);
                    state_next = S_FIN;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(rdata_reg - origin);
                    cc_next    = cc_of(a_dr);
                    state_next = S_OUT;
                end
            end
            S_FIN:
            begin
                rf_we      = 1'b1;
                rf_wd      = rdata_reg;
                cc_next    = cc_of(rdata_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ow_next    = '{KIND_STEP, 3'd0, pc_reg + origin, cc_reg, 1'b1};
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    ow_next = '{KIND_DUMP, di_reg, rf_reg[di_reg], cc_reg,
                                di_reg == 3'd7};
                    di_next = di_reg + 3'd1;
                    if (di_reg == 3'd7)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            cc_reg    <= CC_ZERO;
            halt_reg  <= 1'b0;
            di_reg    <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
                rf_reg[i] <= REG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cc_reg    <= cc_next;
            halt_reg  <= halt_next;
            di_reg    <= di_next;
            ov_reg    <= ov_next;
            if (rf_we)
                rf_reg[rf_wa] <= rf_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg <= ir_next;
        ow_reg <= ow_next;
    end

    // program and data memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

endmodule

// ===== hdl/lc3_instruction_executor.sv =====
// ---------------------------------------------------------------------------
// lc3_instruction_executor
// LC-3 style executor: input queue in front, fetch/execute sequencer behind.
// ---------------------------------------------------------------------------
//  channel | signals                    | direction
//  in      | in_valid/in_ready/in_word  | into block
//  out     | out_valid/out_ready/out_word | out of block
//  cfg     | cfg_we/cfg_data (origin)   | into block
// Load words are written from idle; steps pass fetch, execute and result states,
// LD/LDR add a read state, STI an indirect state and LDI both (registered reads).
// A halt sends eight dump words, one per cycle while out_ready is high.
// The input queue keeps accepting, until its two entries are full, while the sequencer waits on out_ready.
// Reset restores registers to 0x7777, PC 0, zero flag; memory is not cleared.
module lc3_instruction_executor
    import lc3x_pkg::*;
#(
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_word
);

    logic [15:0] origin_reg;
    logic        q_valid, q_pop;
    in_word_t    q_word;

    // origin register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            origin_reg <= '0;
        else if (cfg_we)
            origin_reg <= cfg_data;
    end

    lc3x_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_word(in_word), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
    );

    lc3x_back #(.MEM_WORDS(MEM_WORDS)) u_back (
        .clk(clk), .rst_n(rst_n), .origin(origin_reg), .q_valid(q_valid),
        .q_pop(q_pop), .q_word(q_word), .out_valid(out_valid),
        .out_ready(out_ready), .out_word(out_word)
    );

endmodule

// ===== hdl/lc3x_checker.sv =====
// ---------------------------------------------------------------------------
// lc3x_checker
// Port-level checks of the executor's result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module lc3x_checker
    import lc3x_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // a stalled result word holds
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "result changed while stalled")
    // step and ignore words are always last, with register index zero
    `CHK_IMPLY(a_single, clk, rst_n, out_valid && out_word.kind != KIND_DUMP, out_word.last && out_word.reg_index == 3'd0, "single result not last")
    // dump words are last exactly on register seven
    `CHK_IMPLY(a_dump, clk, rst_n, out_valid && out_word.kind == KIND_DUMP, out_word.last == (out_word.reg_index == 3'd7), "dump last misplaced")
    // kind is never the unused code
    `CHK_IMPLY(a_kind, clk, rst_n, out_valid, out_word.kind != 2'd3, "bad result kind")

endmodule

bind lc3_instruction_executor lc3x_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
    .out_ready(out_ready), .out_word(out_word)
);
